// ----- src/pewt_pkg.sv -----
// Shared types and constants for the periodic event wake timer.
// Used by pewt_front, pewt_back and periodic_event_wake_timer; no dependencies.
package pewt_pkg;

  localparam int MAX_CH      = 4;
  localparam int CH_W        = 2;
  localparam int TIME_W      = 32;
  localparam int PERIOD_W    = 16;
  localparam int TASK_W      = 8;
  localparam int PRIO_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 24;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_WAIT = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RST [MAX_CH] = '{16'd100, 16'd200, 16'd500, 16'd50};

  // Decoded command passed from the front to the back
  typedef struct packed {
    logic              tick;
    logic [TIME_W-1:0] now_ms;
    logic [CH_W-1:0]   channel;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] task_prio;
    logic [PRIO_W-1:0] current_prio;
  } cmd_t;

endpackage

// ----- src/periodic_event_wake_timer.sv -----
// Periodic event wake timer, top level: front queue and back end.
// Depends on pewt_pkg, pewt_front and pewt_back.
//
// Usage:
//   in_*  : stream of items. in_tuser = 0 is a time tick carrying now_ms and
//           current_prio; in_tuser = 1 stores a waiter (task_id, task_prio)
//           in the slot of one channel, replacing any earlier waiter.
//   out_* : one wake item per woken task; out_tlast marks the final wake of a
//           tick. Ticks that wake nothing and all waits give no output.
//   cfg_* : write of a channel period (index 0..3), always ready. Write only
//           while the block is idle.
// Flow: a tick's wakes are first marked pending, then loaded into the output
// register one wake per cycle while out_tready allows; the next tick leaves
// the queue only as the last wake of the previous one is loaded. Waits
// overlap with wake emission, so waits stream back to back.
// Reset: periods and match times return to 100, 200, 500 and 50 ms, all
// waiter slots are empty and the queue is flushed.
// Stall: with out_tready low the output register holds its wake, the
// two-entry command queue fills and in_tready drops.
module periodic_event_wake_timer #(
  parameter int CHANNELS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tuser: req_type
  input  logic                                  in_tuser,
  // tdata: now_ms[31:0], channel[33:32], task_id[41:34], task_prio[47:42],
  //        current_prio[53:48], zero fill[55:54]
  input  logic [pewt_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tuser: wake_valid
  output logic                                  out_tuser,
  // tdata: wake_channel[1:0], wake_task[9:2], wake_prio[15:10], preempt[16],
  //        zero fill[23:17]
  output logic [pewt_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pewt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pewt_pkg::PERIOD_W-1:0]         cfg_data
);

  logic           cmd_valid;
  logic           cmd_ready;
  pewt_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;
  assign out_tuser = 1'b1;

  pewt_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pewt_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/pewt_front.sv -----
// Front end: accepts input items, drops waits on missing channels and
// queues the rest in a two-entry command queue. Depends on pewt_pkg.
module pewt_front #(
  parameter int CHANNELS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tuser: req_type
  input  logic                           in_tuser,
  // tdata: now_ms[31:0], channel[33:32], task_id[41:34], task_prio[47:42],
  //        current_prio[53:48], zero fill
  input  logic [pewt_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output pewt_pkg::cmd_t                 cmd
);

  pewt_pkg::cmd_t cmd_q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  pewt_pkg::cmd_t in_cmd;
  logic           push;
  logic           pop;

  always_comb begin
    in_cmd.tick         = (in_tuser == pewt_pkg::REQ_TICK);
    in_cmd.now_ms       = in_tdata[31:0];
    in_cmd.channel      = in_tdata[33:32];
    in_cmd.task_id      = in_tdata[41:34];
    in_cmd.task_prio    = in_tdata[47:42];
    in_cmd.current_prio = in_tdata[53:48];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = cmd_q_r[rd_ptr_r];

  // drop waits on channels that do not exist
  assign push = in_tvalid && in_tready &&
                (in_cmd.tick || (int'(in_cmd.channel) < CHANNELS));
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ----- src/pewt_back.sv -----
// Back end: channel state, tick compare and advance, waiter slots and the
// serial wake emitter with its output register. Depends on pewt_pkg.
module pewt_back #(
  parameter int CHANNELS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cmd_valid,
  output logic                                  cmd_ready,
  input  pewt_pkg::cmd_t                        cmd,
  input  logic                                  cfg_valid,
  input  logic [pewt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pewt_pkg::PERIOD_W-1:0]         cfg_data,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pewt_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [pewt_pkg::TIME_W-1:0]   next_match_r [CHANNELS];
  logic [pewt_pkg::TIME_W-1:0]   next_match_nxt [CHANNELS];
  logic [pewt_pkg::PERIOD_W-1:0] period_r [CHANNELS];
  logic [CHANNELS-1:0]           wv_r, wv_nxt;
  logic [pewt_pkg::TASK_W-1:0]   wt_r [CHANNELS];
  logic [pewt_pkg::PRIO_W-1:0]   wp_r [CHANNELS];
  logic [CHANNELS-1:0]           pend_r, pend_nxt;
  logic [pewt_pkg::TASK_W-1:0]   rec_task_r [CHANNELS];
  logic [pewt_pkg::PRIO_W-1:0]   rec_prio_r [CHANNELS];
  logic [CHANNELS-1:0]           rec_pre_r;
  logic [CHANNELS-1:0]           rec_load;
  logic                          out_tvalid_r;
  logic [pewt_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                          out_tlast_r;
  logic [IDX_W-1:0]              sel;
  logic                          found;
  logic                          out_load;
  logic [CHANNELS-1:0]           sel_mask;
  logic [CHANNELS-1:0]           rem;
  logic                          cmd_fire;
  logic [IDX_W-1:0]              wait_idx;

  assign wait_idx = cmd.channel[IDX_W-1:0];

  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (pend_r[c] && !found) begin
        sel   = IDX_W'(c);
        found = 1'b1;
      end
    end
    out_load  = (|pend_r) && (!out_tvalid_r || out_tready);
    sel_mask  = out_load ? (CHANNELS'(1) << sel) : '0;
    rem       = pend_r & ~sel_mask;
    // a tick waits until the previous tick's wakes are all handed over
    cmd_ready = !cmd.tick || (rem == '0);
    cmd_fire  = cmd_valid && cmd_ready;

    next_match_nxt = next_match_r;
    wv_nxt         = wv_r;
    pend_nxt       = rem;
    rec_load       = '0;
    if (cmd_fire && cmd.tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (next_match_r[c] <= cmd.now_ms) begin
          next_match_nxt[c] = next_match_r[c] +
                              {{(pewt_pkg::TIME_W-pewt_pkg::PERIOD_W){1'b0}}, period_r[c]};
          if (wv_r[c]) begin
            pend_nxt[c] = 1'b1;
            wv_nxt[c]   = 1'b0;
            rec_load[c] = 1'b1;
          end
        end
      end
    end else if (cmd_fire) begin
      wv_nxt[wait_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        next_match_r[c] <= {{(pewt_pkg::TIME_W-pewt_pkg::PERIOD_W){1'b0}},
                            pewt_pkg::PERIOD_RST[c]};
        period_r[c]     <= pewt_pkg::PERIOD_RST[c];
      end
      wv_r         <= '0;
      pend_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      next_match_r <= next_match_nxt;
      wv_r         <= wv_nxt;
      pend_r       <= pend_nxt;
      if (cfg_valid && (int'(cfg_index) < CHANNELS)) begin
        period_r[cfg_index[IDX_W-1:0]] <= cfg_data;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // waiter slots reset to zero; entries are only read while valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wt_r[c] <= '0;
        wp_r[c] <= '0;
      end
    end else if (cmd_fire && !cmd.tick) begin
      wt_r[wait_idx] <= cmd.task_id;
      wp_r[wait_idx] <= cmd.task_prio;
    end
  end

  // snapshot woken waiters so later waits may refill the slots
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (rec_load[c]) begin
        rec_task_r[c] <= wt_r[c];
        rec_prio_r[c] <= wp_r[c];
        rec_pre_r[c]  <= (wp_r[c] < cmd.current_prio);
      end
    end
    if (out_load) begin
      out_tdata_r <= {7'd0, rec_pre_r[sel], rec_prio_r[sel], rec_task_r[sel],
                      pewt_pkg::CH_W'(sel)};
      out_tlast_r <= (rem == '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for periodic_event_wake_timer: a directed table, then
// random waits and ticks over several period settings, checked against a predictor.
// Depends on pewt_pkg and the RTL of periodic_event_wake_timer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pewt_pkg::*;

  localparam int NUM_CH = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_CH0,
    REG_PERIOD_CH1,
    REG_PERIOD_CH2,
    REG_PERIOD_CH3
  } period_reg_e;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic              preempt;
    logic              is_last;
  } wake_t;

  typedef struct {
    logic              req;
    logic [TIME_W-1:0] now;
    logic [CH_W-1:0]   ch;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] tprio;
    logic [PRIO_W-1:0] cprio;
    bit                typed;
    wake_t             wake;
  } dir_row_t;

  localparam wake_t NO_WAKE = '0;
  localparam int NUM_ROWS = 18;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic                    in_tuser;
  logic [IN_DATA_W-1:0]    in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic                    out_tuser;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tlast;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [PERIOD_W-1:0]     cfg_data;

  periodic_event_wake_timer #(
    .CHANNELS(NUM_CH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Timer state as the block should hold it
  logic [PERIOD_W-1:0] period_ms [NUM_CH];
  logic [TIME_W-1:0]   match_ms  [NUM_CH];
  logic                slot_busy [NUM_CH];
  logic [TASK_W-1:0]   slot_task [NUM_CH];
  logic [PRIO_W-1:0]   slot_prio [NUM_CH];
  wake_t               pending_wakes [$];

  int                  errors;
  int unsigned         cycle_cnt;
  logic [TIME_W-1:0]   clock_ms;
  bit                  hold_req;
  bit                  hold_done;
  dir_row_t            dir_rows [NUM_ROWS];
  wake_t               want;

  function automatic void advance_timer(input logic req, input logic [TIME_W-1:0] now,
                                        input logic [CH_W-1:0] ch,
                                        input logic [TASK_W-1:0] tid,
                                        input logic [PRIO_W-1:0] tprio,
                                        input logic [PRIO_W-1:0] cprio);
    wake_t woken [$];
    wake_t w;
    if (req == REQ_WAIT) begin
      slot_busy[ch] = 1'b1;
      slot_task[ch] = tid;
      slot_prio[ch] = tprio;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (match_ms[c] <= now) begin
          // one period per due tick, wrapping at 32 bits
          match_ms[c] = match_ms[c] + {{(TIME_W-PERIOD_W){1'b0}}, period_ms[c]};
          if (slot_busy[c]) begin
            w.ch      = CH_W'(c);
            w.task_id = slot_task[c];
            w.prio    = slot_prio[c];
            w.preempt = slot_prio[c] < cprio;
            w.is_last = 1'b0;
            woken.push_back(w);
            slot_busy[c] = 1'b0;
          end
        end
      end
      if (woken.size() > 0) woken[woken.size()-1].is_last = 1'b1;
      foreach (woken[i]) pending_wakes.push_back(woken[i]);
    end
  endfunction

  function automatic void check_field(input string what, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: wake %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  task automatic write_period(input period_reg_e idx, input logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    period_ms[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] p0, input logic [PERIOD_W-1:0] p1,
                             input logic [PERIOD_W-1:0] p2, input logic [PERIOD_W-1:0] p3);
    write_period(REG_PERIOD_CH0, p0);
    write_period(REG_PERIOD_CH1, p1);
    write_period(REG_PERIOD_CH2, p2);
    write_period(REG_PERIOD_CH3, p3);
  endtask

  // Offer one item, wait for the handshake, then record what it should wake
  task automatic send_item(input logic req, input logic [TIME_W-1:0] now,
                           input logic [CH_W-1:0] ch, input logic [TASK_W-1:0] tid,
                           input logic [PRIO_W-1:0] tprio, input logic [PRIO_W-1:0] cprio,
                           input bit typed, input wake_t typed_wake);
    int r;
    int gap;
    int n0;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, cprio, tprio, tid, ch, now};
    do @(posedge clk); while (!in_tready);
    n0 = pending_wakes.size();
    advance_timer(req, now, ch, tid, tprio, cprio);
    if (typed) begin
      while (pending_wakes.size() > n0) void'(pending_wakes.pop_back());
      pending_wakes.push_back(typed_wake);
    end
  endtask

  // Drop valid and let the block go quiet before touching the periods
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_wakes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int unsigned step_max);
    int r;
    logic [TIME_W-1:0] now;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_item(REQ_WAIT, $urandom, CH_W'($urandom), TASK_W'($urandom), PRIO_W'($urandom),
                  PRIO_W'($urandom), 1'b0, NO_WAKE);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          now = clock_ms;
        end else if (r < 95) begin
          now = $urandom;
        end else begin
          now = clock_ms;
        end
        send_item(REQ_TICK, now, CH_W'($urandom), TASK_W'($urandom), PRIO_W'($urandom),
                  PRIO_W'($urandom), 1'b0, NO_WAKE);
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_wakes.size() == 0) begin
        errors++;
        $display("%0t: unexpected wake, expected none, got tdata=%h tlast=%b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_wakes.pop_front();
        check_field("valid", 1, out_tuser);
        check_field("channel", want.ch, out_tdata[1:0]);
        check_field("task", want.task_id, out_tdata[9:2]);
        check_field("prio", want.prio, out_tdata[15:10]);
        check_field("preempt", want.preempt, out_tdata[16]);
        check_field("last", want.is_last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[periodic_event_wake_timer] ERROR");
      $finish;
    end
  end

  // Receiver: random ready pattern, plus one long hold-off to back up the input
  initial begin
    int r;
    int run_left;
    run_left = 0;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_tready <= 1'b1;
          run_left = $urandom_range(0, 23);
        end else if (r < 95) begin
          out_tready <= 1'b0;
          run_left = $urandom_range(0, 2);
        end else begin
          out_tready <= 1'b0;
          run_left = $urandom_range(7, 39);
        end
      end
    end
  end

  initial begin
    errors    = 0;
    cycle_cnt = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_TICK;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PERIOD_CH0;
    cfg_data  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      period_ms[c] = PERIOD_RST[c];
      match_ms[c]  = {{(TIME_W-PERIOD_W){1'b0}}, PERIOD_RST[c]};
      slot_busy[c] = 1'b0;
      slot_task[c] = '0;
      slot_prio[c] = '0;
    end

    // Reset periods: 100, 200, 500, 50
    dir_rows = '{
      '{REQ_TICK, 32'd0,          2'd0, 8'h00, 6'd0,  6'd0,  1'b0, NO_WAKE},
      '{REQ_WAIT, 32'hFFFFFFFF,   2'd0, 8'hFF, 6'd63, 6'd63, 1'b0, NO_WAKE},
      '{REQ_WAIT, 32'd0,          2'd3, 8'h00, 6'd0,  6'd0,  1'b0, NO_WAKE},
      '{REQ_TICK, 32'd49,         2'd3, 8'hFF, 6'd63, 6'd63, 1'b0, NO_WAKE},
      // channel 3 due exactly at its match time, urgent task preempts
      '{REQ_TICK, 32'd50,         2'd0, 8'h00, 6'd0,  6'd63, 1'b1,
        wake_t'{2'd3, 8'h00, 6'd0, 1'b1, 1'b1}},
      '{REQ_TICK, 32'd99,         2'd0, 8'h00, 6'd0,  6'd0,  1'b0, NO_WAKE},
      // channel 0 wakes, channel 3 due with an empty slot
      '{REQ_TICK, 32'd100,        2'd0, 8'h00, 6'd0,  6'd0,  1'b1,
        wake_t'{2'd0, 8'hFF, 6'd63, 1'b0, 1'b1}},
      '{REQ_WAIT, 32'd0,          2'd1, 8'h5A, 6'd31, 6'd0,  1'b0, NO_WAKE},
      '{REQ_WAIT, 32'd0,          2'd2, 8'hA5, 6'd32, 6'd0,  1'b0, NO_WAKE},
      '{REQ_WAIT, 32'd0,          2'd0, 8'h01, 6'd1,  6'd0,  1'b0, NO_WAKE},
      // overwrite the waiter of channel 0
      '{REQ_WAIT, 32'd0,          2'd0, 8'h02, 6'd2,  6'd0,  1'b0, NO_WAKE},
      '{REQ_WAIT, 32'd0,          2'd3, 8'h03, 6'd3,  6'd0,  1'b0, NO_WAKE},
      // every channel wakes on one tick
      '{REQ_TICK, 32'hFFFFFFFF,   2'd0, 8'h00, 6'd0,  6'd32, 1'b0, NO_WAKE},
      '{REQ_TICK, 32'hFFFFFFFF,   2'd0, 8'h00, 6'd0,  6'd63, 1'b0, NO_WAKE},
      '{REQ_WAIT, 32'd0,          2'd2, 8'hC3, 6'd10, 6'd0,  1'b0, NO_WAKE},
      // equal priority does not preempt
      '{REQ_TICK, 32'hFFFFFFFF,   2'd0, 8'h00, 6'd0,  6'd10, 1'b1,
        wake_t'{2'd2, 8'hC3, 6'd10, 1'b0, 1'b1}},
      '{REQ_WAIT, 32'd0,          2'd1, 8'h3C, 6'd63, 6'd0,  1'b0, NO_WAKE},
      '{REQ_TICK, 32'd800,        2'd0, 8'h00, 6'd0,  6'd63, 1'b0, NO_WAKE}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].now, dir_rows[i].ch, dir_rows[i].task_id,
                dir_rows[i].tprio, dir_rows[i].cprio, dir_rows[i].typed, dir_rows[i].wake);
    wait_idle();

    clock_ms = 32'd2100;
    // Periods of 1 ms on every channel; the long output hold-off lands in this phase
    set_periods(16'd1, 16'd1, 16'd1, 16'd1);
    hold_req = 1'b1;
    run_phase(110, 3);
    wait_idle();

    set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(105, 80000);
    wait_idle();

    // Channel 1 with a zero period fires on every tick once due
    set_periods(PERIOD_W'($urandom_range(1, 300)), 16'd0, PERIOD_W'($urandom_range(1, 300)),
                PERIOD_W'($urandom_range(1, 65535)));
    run_phase(105, 250);
    wait_idle();

    set_periods(PERIOD_W'($urandom_range(1, 1000)), PERIOD_W'($urandom_range(1, 1000)),
                PERIOD_W'($urandom_range(1, 1000)), PERIOD_W'($urandom_range(1, 1000)));
    run_phase(105, 1200);
    wait_idle();

    if (errors == 0) begin
      $display("[periodic_event_wake_timer] OK");
    end else begin
      $display("[periodic_event_wake_timer] ERROR");
    end
    $finish;
  end

endmodule
